// ===== sv/scr_pkg.sv =====
// Shared types, constants and command codes of the task scheduler.
package scr_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int KEY_W      = 32;

  localparam logic [2:0] CMD_ALLOC     = 3'd0;
  localparam logic [2:0] CMD_FREE      = 3'd1;
  localparam logic [2:0] CMD_RUN       = 3'd2;
  localparam logic [2:0] CMD_SLEEP     = 3'd3;
  localparam logic [2:0] CMD_STOP      = 3'd4;
  localparam logic [2:0] CMD_STOP_FREE = 3'd5;
  localparam logic [2:0] CMD_SWITCH    = 3'd6;
  localparam logic [2:0] CMD_UNUSED    = 3'd7;

  localparam logic [ID_W-1:0] BOOT_ID      = 8'd3;
  localparam logic [ID_W-1:0] FIRST_NEW_ID = 8'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [7:0]  priority_req;
    logic [23:0] sleep_ticks;
    logic [31:0] current_time;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] alloc_slot;
    logic [7:0] alloc_id;
    logic [7:0] active_id;
    logic       switched;
    logic       restart_slice;
    logic       empty_error;
  } out_t;

  typedef enum logic [1:0] {LOP_NOP, LOP_REMOVE, LOP_INSERT, LOP_APPEND} lop_e;
  typedef enum logic [1:0] {SEL_HOLD, SEL_NEXT, SEL_PREV, SEL_LOAD} sel_e;

  typedef struct packed {
    lop_e              op;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } list_req_t;

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] rd_slot;
  } list_stat_t;

endpackage

// ===== sv/scr_cell.sv =====
// One list entry: slot number and sort key, shifted to or from its neighbors.
module scr_cell import scr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sel_e              sel_i,
  input  logic [SLOT_W-1:0] prev_slot_i,
  input  logic [KEY_W-1:0]  prev_key_i,
  input  logic [SLOT_W-1:0] next_slot_i,
  input  logic [KEY_W-1:0]  next_key_i,
  input  logic [SLOT_W-1:0] new_slot_i,
  input  logic [KEY_W-1:0]  new_key_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic [KEY_W-1:0]  key_o,
  output logic              match_o,
  output logic              le_o
);

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [KEY_W-1:0]  key_q, key_d;

  always_comb begin
    unique case (sel_i)
      SEL_HOLD: begin slot_d = slot_q;      key_d = key_q;      end
      SEL_NEXT: begin slot_d = next_slot_i; key_d = next_key_i; end
      SEL_PREV: begin slot_d = prev_slot_i; key_d = prev_key_i; end
      SEL_LOAD: begin slot_d = new_slot_i;  key_d = new_key_i;  end
      default:  begin slot_d = slot_q;      key_d = key_q;      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      key_q  <= '0;
    end else begin
      slot_q <= slot_d;
      key_q  <= key_d;
    end
  end

  assign slot_o  = slot_q;
  assign key_o   = key_q;
  assign match_o = (slot_q == new_slot_i);
  assign le_o    = (key_q <= new_key_i);

endmodule

// ===== sv/scr_list.sv =====
// Ordered slot list built from a row of cells: find, remove, sorted insert, append.
module scr_list import scr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  cnt_init_i,
  input  list_req_t         req_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output list_stat_t        stat_o
);

  logic [SLOT_W-1:0] slot_w [TASK_SLOTS];
  logic [KEY_W-1:0]  key_w  [TASK_SLOTS];
  logic [SLOT_W-1:0] prev_slot_w [TASK_SLOTS];
  logic [KEY_W-1:0]  prev_key_w  [TASK_SLOTS];
  logic [SLOT_W-1:0] next_slot_w [TASK_SLOTS];
  logic [KEY_W-1:0]  next_key_w  [TASK_SLOTS];
  sel_e              sel_w  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] match_w, le_w, hit_vec, before_vec, before_prev;
  logic [SLOT_W-1:0] hit_idx;
  logic              hit;
  logic              has_room;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] rd_slot;

  for (genvar j = 0; j < TASK_SLOTS; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign prev_slot_w[j] = slot_w[j];
      assign prev_key_w[j]  = key_w[j];
    end else begin : g_mid
      assign prev_slot_w[j] = slot_w[j-1];
      assign prev_key_w[j]  = key_w[j-1];
    end
    if (j == TASK_SLOTS-1) begin : g_last
      assign next_slot_w[j] = slot_w[j];
      assign next_key_w[j]  = key_w[j];
    end else begin : g_body
      assign next_slot_w[j] = slot_w[j+1];
      assign next_key_w[j]  = key_w[j+1];
    end

    scr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .sel_i       (sel_w[j]),
      .prev_slot_i (prev_slot_w[j]),
      .prev_key_i  (prev_key_w[j]),
      .next_slot_i (next_slot_w[j]),
      .next_key_i  (next_key_w[j]),
      .new_slot_i  (req_i.slot),
      .new_key_i   (req_i.key),
      .slot_o      (slot_w[j]),
      .key_o       (key_w[j]),
      .match_o     (match_w[j]),
      .le_o        (le_w[j])
    );
  end

  always_comb begin
    for (int j = 0; j < TASK_SLOTS; j++) begin
      hit_vec[j]    = (CNT_W'(j) < count_q) && match_w[j];
      before_vec[j] = (CNT_W'(j) < count_q) && le_w[j];
    end
    before_prev = {before_vec[TASK_SLOTS-2:0], 1'b1};
    hit         = |hit_vec;
    hit_idx     = '0;
    for (int j = TASK_SLOTS-1; j >= 0; j--) begin
      if (hit_vec[j]) hit_idx = SLOT_W'(j);
    end
  end

  assign has_room = (count_q < CNT_W'(TASK_SLOTS));

  // Per-cell shift control; the entry just past the count keeps its old value on remove.
  always_comb begin
    count_d = count_q;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      sel_w[j] = SEL_HOLD;
      unique case (req_i.op)
        LOP_REMOVE: begin
          if (hit && (SLOT_W'(j) >= hit_idx) && (CNT_W'(j + 1) < count_q)) sel_w[j] = SEL_NEXT;
        end
        LOP_INSERT: begin
          if (has_room && !before_vec[j] && (CNT_W'(j) <= count_q)) begin
            sel_w[j] = before_prev[j] ? SEL_LOAD : SEL_PREV;
          end
        end
        LOP_APPEND: begin
          if (has_room && (CNT_W'(j) == count_q)) sel_w[j] = SEL_LOAD;
        end
        default: sel_w[j] = SEL_HOLD;
      endcase
    end
    unique case (req_i.op)
      LOP_REMOVE: if (hit && (count_q != '0)) count_d = count_q - 1'b1;
      LOP_INSERT, LOP_APPEND: if (has_room) count_d = count_q + 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_comb begin
    rd_slot = '0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (rd_idx_i == SLOT_W'(j)) rd_slot = slot_w[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= cnt_init_i;
    else         count_q <= count_d;
  end

  assign stat_o.hit     = hit;
  assign stat_o.count   = count_q;
  assign stat_o.rd_slot = rd_slot;

endmodule

// ===== sv/priority_round_robin_task_scheduler.sv =====
// Top level of the task scheduler: slot table, command sequencer and three lists.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_t)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (out_t)
//
// One command at a time; the alloc free-slot search looks at one slot a cycle.
// Each list operation is a single registered update of the cell row; the switch reads
// the running list through one read port, first in state SWA and then in state SWB.
// Reset leaves slot 0 running with id 3; no clearing pass.
// A result held by out_stall_i keeps the block from finishing the next command.
module priority_round_robin_task_scheduler import scr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ASRCH = 4'd1;
  localparam logic [3:0] ST_FREE  = 4'd2;
  localparam logic [3:0] ST_RUN   = 4'd3;
  localparam logic [3:0] ST_RINS  = 4'd4;
  localparam logic [3:0] ST_SLEEP = 4'd5;
  localparam logic [3:0] ST_SINS  = 4'd6;
  localparam logic [3:0] ST_STOP  = 4'd7;
  localparam logic [3:0] ST_SAPP  = 4'd8;
  localparam logic [3:0] ST_SWA   = 4'd9;
  localparam logic [3:0] ST_SWB   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  in_t        req_q, req_d;

  logic [TASK_SLOTS-1:0] used_q, used_d;
  logic [ID_W-1:0]   id_q [TASK_SLOTS];
  logic [ID_W-1:0]   id_d [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_q [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_d [TASK_SLOTS];

  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [ID_W-1:0]   cur_id_q, cur_id_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] srch_q, srch_d;
  logic [CNT_W-1:0]  step_q, step_d;
  logic [SLOT_W-1:0] nxt_q, nxt_d;
  logic [ID_W-1:0]   new_id_q, new_id_d;

  logic              ok_q, ok_d, sw_q, sw_d, rs_q, rs_d, emp_q, emp_d;
  logic [SLOT_W-1:0] aslot_q, aslot_d;
  logic [ID_W-1:0]   aid_q, aid_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  list_req_t  run_req, sleep_req, stop_req;
  list_stat_t run_stat, sleep_stat, stop_stat;
  logic [SLOT_W-1:0] rd_idx, nxt;
  logic [ID_W-1:0]   rd_id;
  logic              accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next running position, round-robin.
  always_comb begin
    if ({1'b0, pos_q} >= run_stat.count)                  nxt = '0;
    else if (CNT_W'({1'b0, pos_q} + 1'b1) == run_stat.count) nxt = '0;
    else                                                  nxt = pos_q + 1'b1;
  end

  assign rd_idx = (state_q == ST_SWA) ? nxt : pos_q;
  assign rd_id  = id_q[run_stat.rd_slot];

  always_comb begin
    run_req   = '{op: LOP_NOP, slot: req_q.slot, key: '0};
    sleep_req = '{op: LOP_NOP, slot: req_q.slot, key: '0};
    stop_req  = '{op: LOP_NOP, slot: req_q.slot, key: '0};
    unique case (state_q)
      ST_ASRCH: begin
        stop_req.slot = srch_q;
        if (!used_q[srch_q]) stop_req.op = LOP_APPEND;
      end
      ST_FREE: stop_req.op = LOP_REMOVE;
      ST_RUN: begin
        stop_req.op = LOP_REMOVE;
        if (!stop_stat.hit) sleep_req.op = LOP_REMOVE;
      end
      ST_RINS: begin
        run_req.op  = LOP_INSERT;
        run_req.key = KEY_W'(prio_q[req_q.slot]);
      end
      ST_SLEEP: if (req_q.sleep_ticks != '0) run_req.op = LOP_REMOVE;
      ST_SINS: begin
        sleep_req.op  = LOP_INSERT;
        sleep_req.key = req_q.current_time + KEY_W'(req_q.sleep_ticks);
      end
      ST_STOP: begin
        run_req.op = LOP_REMOVE;
        if (!run_stat.hit) sleep_req.op = LOP_REMOVE;
      end
      ST_SAPP: stop_req.op = LOP_APPEND;
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    used_d      = used_q;
    id_d        = id_q;
    prio_d      = prio_q;
    cursor_d    = cursor_q;
    next_id_d   = next_id_q;
    cur_id_d    = cur_id_q;
    pos_d       = pos_q;
    srch_d      = srch_q;
    step_d      = step_q;
    nxt_d       = nxt_q;
    new_id_d    = new_id_q;
    ok_d        = ok_q;
    sw_d        = sw_q;
    rs_d        = rs_q;
    emp_d       = emp_q;
    aslot_d     = aslot_q;
    aid_d       = aid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = in_data_i;
          ok_d    = 1'b0;
          sw_d    = 1'b0;
          rs_d    = 1'b0;
          emp_d   = 1'b0;
          aslot_d = '0;
          aid_d   = '0;
          unique case (in_data_i.cmd)
            CMD_ALLOC: begin
              srch_d  = cursor_q[SLOT_W-1:0];
              step_d  = '0;
              state_d = (cursor_q < CNT_W'(TASK_SLOTS)) ? ST_ASRCH : ST_DONE;
            end
            CMD_FREE:                state_d = ST_FREE;
            CMD_RUN:                 state_d = ST_RUN;
            CMD_SLEEP:               state_d = ST_SLEEP;
            CMD_STOP, CMD_STOP_FREE: state_d = ST_STOP;
            CMD_SWITCH: begin
              ok_d    = 1'b1;
              state_d = ST_SWA;
            end
            default:                 state_d = ST_DONE;
          endcase
        end
      end
      ST_ASRCH: begin
        if (used_q[srch_q] && (step_q < CNT_W'(TASK_SLOTS))) begin
          srch_d = srch_q + 1'b1;
          step_d = step_q + 1'b1;
        end else begin
          if (!used_q[srch_q]) begin
            used_d[srch_q] = 1'b1;
            id_d[srch_q]   = next_id_q;
            prio_d[srch_q] = req_q.priority_req;
            next_id_d      = next_id_q + 1'b1;
            cursor_d       = CNT_W'({1'b0, srch_q} + 1'b1);
            ok_d           = 1'b1;
            aslot_d        = srch_q;
            aid_d          = next_id_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_FREE: begin
        if (stop_stat.hit) begin
          if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
          used_d[req_q.slot] = 1'b0;
          ok_d               = 1'b1;
        end
        state_d = (req_q.cmd == CMD_STOP_FREE) ? ST_SWA : ST_DONE;
      end
      ST_RUN:  state_d = (stop_stat.hit || sleep_stat.hit) ? ST_RINS : ST_DONE;
      ST_RINS: begin
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end
      ST_SLEEP: begin
        if (run_stat.hit) begin
          ok_d    = 1'b1;
          state_d = (req_q.sleep_ticks != '0) ? ST_SINS : ST_SWA;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SINS: state_d = ST_SWA;
      ST_STOP: begin
        if (run_stat.hit || sleep_stat.hit) begin
          ok_d    = 1'b1;
          state_d = ST_SAPP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SAPP: state_d = (req_q.cmd == CMD_STOP_FREE) ? ST_FREE : ST_SWA;
      ST_SWA: begin
        if (run_stat.count == '0) begin
          emp_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          nxt_d    = nxt;
          new_id_d = rd_id;
          state_d  = ST_SWB;
        end
      end
      ST_SWB: begin
        // Compare against the entry at the old position, even past the count.
        cur_id_d = new_id_q;
        rs_d     = 1'b1;
        if (new_id_q != rd_id) begin
          pos_d = nxt_q;
          sw_d  = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.ok            = ok_q;
          out_d.alloc_slot    = aslot_q;
          out_d.alloc_id      = aid_q;
          out_d.active_id     = cur_id_q;
          out_d.switched      = sw_q;
          out_d.restart_slice = rs_q;
          out_d.empty_error   = emp_q;
          state_d             = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= TASK_SLOTS'(1);
      for (int j = 0; j < TASK_SLOTS; j++) begin
        id_q[j]   <= (j == 0) ? BOOT_ID : '0;
        prio_q[j] <= '0;
      end
      cursor_q    <= CNT_W'(1);
      next_id_q   <= FIRST_NEW_ID;
      cur_id_q    <= BOOT_ID;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      id_q        <= id_d;
      prio_q      <= prio_d;
      cursor_q    <= cursor_d;
      next_id_q   <= next_id_d;
      cur_id_q    <= cur_id_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    srch_q   <= srch_d;
    step_q   <= step_d;
    nxt_q    <= nxt_d;
    new_id_q <= new_id_d;
    ok_q     <= ok_d;
    sw_q     <= sw_d;
    rs_q     <= rs_d;
    emp_q    <= emp_d;
    aslot_q  <= aslot_d;
    aid_q    <= aid_d;
    out_q    <= out_d;
  end

  scr_list u_run_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cnt_init_i (CNT_W'(1)),
    .req_i      (run_req),
    .rd_idx_i   (rd_idx),
    .stat_o     (run_stat)
  );

  scr_list u_sleep_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cnt_init_i ('0),
    .req_i      (sleep_req),
    .rd_idx_i   (rd_idx),
    .stat_o     (sleep_stat)
  );

  scr_list u_stop_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cnt_init_i ('0),
    .req_i      (stop_req),
    .rd_idx_i   (rd_idx),
    .stat_o     (stop_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/scr_checker.sv =====
// Port-level checks of the task scheduler, bound to the top level.
module scr_checker import scr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a command is in progress");

  a_switch_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.switched |-> out_data_o.restart_slice && out_data_o.ok)
    else $error("switch without slice restart");

  a_empty_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_error |->
      !out_data_o.switched && !out_data_o.restart_slice)
    else $error("switch reported on empty running list");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> (out_data_o.alloc_id == '0) && !out_data_o.restart_slice)
    else $error("failed command reported effects");

endmodule

bind priority_round_robin_task_scheduler scr_checker u_scr_checker (.*);

// ===== tb/scr_checker.sv =====
// Checker for the task scheduler: predicts each result and compares it with the block's output.
`timescale 1ns / 100ps
module scr_scoreboard import scr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_o,
  input  in_t  in_data_i,
  input  logic out_valid_o,
  input  logic out_stall_i,
  input  out_t out_data_o,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o
);

  logic [3:0]  task_list_run   [TASK_SLOTS];
  logic [3:0]  task_list_sleep [TASK_SLOTS];
  logic [3:0]  task_list_stop  [TASK_SLOTS];
  logic        used_q   [TASK_SLOTS];
  logic [7:0]  id_q     [TASK_SLOTS];
  logic [7:0]  prio_q   [TASK_SLOTS];
  logic [31:0] wake_q   [TASK_SLOTS];
  int          run_cnt, sleep_cnt, stop_cnt, run_pos, cursor;
  logic [7:0]  fresh_id, cur_id;
  logic        sw_sw, sw_rs, sw_em;
  out_t        result_q[$];
  int          fails, results;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();
  assign results_o    = results;

  function automatic int find_slot(ref logic [3:0] lst[TASK_SLOTS], input int cnt,
                                   input int s);
    for (int i = 0; i < cnt && i < TASK_SLOTS; i++)
      if (lst[i] == s) return i;
    return TASK_SLOTS;
  endfunction

  // Shift left; the old last entry stays behind.
  function automatic void drop_entry(ref logic [3:0] lst[TASK_SLOTS], ref int cnt,
                                     input int idx);
    for (int j = idx + 1; j < cnt && j < TASK_SLOTS; j++) lst[j-1] = lst[j];
    if (cnt > 0) cnt--;
  endfunction

  function automatic void insert_running(int s);
    int p;
    p = 0;
    if (run_cnt >= TASK_SLOTS) return;
    while (p < run_cnt && prio_q[task_list_run[p]] <= prio_q[s]) p++;
    for (int j = run_cnt; j > p; j--) task_list_run[j] = task_list_run[j-1];
    task_list_run[p] = 4'(s);
    run_cnt++;
  endfunction

  function automatic void insert_sleeping(int s);
    int p;
    p = 0;
    if (sleep_cnt >= TASK_SLOTS) return;
    while (p < sleep_cnt && wake_q[task_list_sleep[p]] <= wake_q[s]) p++;
    for (int j = sleep_cnt; j > p; j--) task_list_sleep[j] = task_list_sleep[j-1];
    task_list_sleep[p] = 4'(s);
    sleep_cnt++;
  endfunction

  function automatic void pick_next();
    int nxt;
    logic [7:0] nid, oid;
    if (run_cnt == 0) begin
      sw_em = 1'b1;
      return;
    end
    nxt = (run_pos >= run_cnt) ? 0 : (run_pos + 1) % run_cnt;
    nid = id_q[task_list_run[nxt]];
    oid = id_q[task_list_run[run_pos % TASK_SLOTS]];
    cur_id = nid;
    sw_rs = 1'b1;
    if (nid != oid) begin
      run_pos = nxt;
      sw_sw = 1'b1;
    end
  endfunction

  function automatic bit stop_task(int s);
    int i;
    i = find_slot(task_list_run, run_cnt, s);
    if (i < TASK_SLOTS) drop_entry(task_list_run, run_cnt, i);
    else begin
      i = find_slot(task_list_sleep, sleep_cnt, s);
      if (i >= TASK_SLOTS) return 0;
      drop_entry(task_list_sleep, sleep_cnt, i);
    end
    if (stop_cnt < TASK_SLOTS) begin
      task_list_stop[stop_cnt] = 4'(s);
      stop_cnt++;
    end
    return 1;
  endfunction

  function automatic bit release_task(int s);
    int i;
    i = find_slot(task_list_stop, stop_cnt, s);
    if (i >= TASK_SLOTS) return 0;
    drop_entry(task_list_stop, stop_cnt, i);
    if (cursor > 0) cursor--;
    used_q[s] = 1'b0;
    return 1;
  endfunction

  function automatic out_t schedule_step(in_t t);
    out_t r;
    int i, c, s;
    r = '0;
    s = t.slot;
    sw_sw = 0; sw_rs = 0; sw_em = 0;
    case (t.cmd)
      CMD_ALLOC: begin
        if (cursor < TASK_SLOTS) begin
          c = cursor;
          for (int k = 0; k < TASK_SLOTS && used_q[c]; k++) c = (c + 1) % TASK_SLOTS;
          if (!used_q[c]) begin
            used_q[c] = 1'b1;
            id_q[c] = fresh_id;
            fresh_id = fresh_id + 8'd1;
            prio_q[c] = t.priority_req;
            wake_q[c] = '0;
            if (stop_cnt < TASK_SLOTS) begin
              task_list_stop[stop_cnt] = 4'(c);
              stop_cnt++;
            end
            cursor = c + 1;
            r.ok = 1;
            r.alloc_slot = 4'(c);
            r.alloc_id = id_q[c];
          end
        end
      end
      CMD_FREE: r.ok = release_task(s);
      CMD_RUN: begin
        i = find_slot(task_list_stop, stop_cnt, s);
        if (i < TASK_SLOTS) begin
          drop_entry(task_list_stop, stop_cnt, i);
          insert_running(s);
          r.ok = 1;
        end else begin
          i = find_slot(task_list_sleep, sleep_cnt, s);
          if (i < TASK_SLOTS) begin
            drop_entry(task_list_sleep, sleep_cnt, i);
            insert_running(s);
            r.ok = 1;
          end
        end
      end
      CMD_SLEEP: begin
        i = find_slot(task_list_run, run_cnt, s);
        if (i < TASK_SLOTS) begin
          if (t.sleep_ticks != 0) begin
            drop_entry(task_list_run, run_cnt, i);
            wake_q[s] = t.current_time + {8'd0, t.sleep_ticks};
            insert_sleeping(s);
          end
          pick_next();
          r.ok = 1;
        end
      end
      CMD_STOP, CMD_STOP_FREE: begin
        if (stop_task(s)) begin
          if (t.cmd == CMD_STOP_FREE) void'(release_task(s));
          pick_next();
          r.ok = 1;
        end
      end
      CMD_SWITCH: begin
        pick_next();
        r.ok = 1;
      end
      default: ;
    endcase
    r.active_id = cur_id;
    r.switched = sw_sw;
    r.restart_slice = sw_rs;
    r.empty_error = sw_em;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        used_q[i] = 0; id_q[i] = 0; prio_q[i] = 0; wake_q[i] = 0;
        task_list_run[i] = 0; task_list_sleep[i] = 0; task_list_stop[i] = 0;
      end
      used_q[0] = 1;
      id_q[0] = BOOT_ID;
      run_cnt = 1; sleep_cnt = 0; stop_cnt = 0; run_pos = 0; cursor = 1;
      fresh_id = FIRST_NEW_ID;
      cur_id = BOOT_ID;
      result_q.delete();
      fails = 0;
      results = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected result %p", $realtime, out_data_o);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data_o !== exp_r) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, out_data_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) result_q.push_back(schedule_step(in_data_i));
    end
  end

endmodule

// ===== tb/tb_priority_round_robin_task_scheduler.sv =====
// Testbench top for the task scheduler: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_priority_round_robin_task_scheduler;
  import scr_pkg::*;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_t  in_data;
  out_t out_data;
  int   fail_count, pending, results;
  int   send_idle, recv_idle, n_cmds;

  priority_round_robin_task_scheduler dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  scr_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data), .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stall, redrawn each falling edge.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Start on a fresh falling edge, hold valid until the transaction is accepted, then drop it.
  task automatic send_cmd(in_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_data  <= t;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
    n_cmds++;
  endtask

  function automatic in_t make_cmd(logic [2:0] c, logic [3:0] s);
    in_t t;
    t.cmd = c;
    t.slot = s;
    t.priority_req = 8'($urandom);
    t.sleep_ticks = 24'($urandom);
    t.current_time = $urandom;
    return t;
  endfunction

  // Mostly meaningful commands over a few priorities; some noise and junk codes.
  function automatic in_t rand_cmd();
    in_t t;
    int w;
    w = $urandom_range(99);
    t = make_cmd(3'($urandom_range(6)), 4'($urandom_range(15)));
    if (w < 20) t.cmd = CMD_ALLOC;
    else if (w < 35) t.cmd = CMD_RUN;
    else if (w < 50) t.cmd = CMD_SLEEP;
    else if (w < 60) t.cmd = CMD_STOP;
    else if (w < 67) t.cmd = CMD_STOP_FREE;
    else if (w < 75) t.cmd = CMD_FREE;
    else if (w < 90) t.cmd = CMD_SWITCH;
    else if (w < 93) t.cmd = CMD_UNUSED;
    if ($urandom_range(3) != 0) t.priority_req = 8'($urandom_range(3));
    if ($urandom_range(3) == 0) t.sleep_ticks = '0;
    else if ($urandom_range(1)) t.sleep_ticks = 24'($urandom_range(20));
    if ($urandom_range(3) == 0) t.current_time = 32'hFFFF_FFF0 + $urandom_range(15);
    return t;
  endfunction

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    in_t t;
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    n_cmds = 0;
    send_idle = 16;
    recv_idle = 83;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed: empty run list, every command, extremes.
    send_cmd(make_cmd(CMD_SWITCH, 4'd0));
    t = make_cmd(CMD_SLEEP, 4'd0); t.sleep_ticks = '0; send_cmd(t);
    for (int i = 0; i < 3; i++) begin
      t = make_cmd(CMD_ALLOC, 4'd0); t.priority_req = (i == 0) ? 8'hFF : 8'h00;
      send_cmd(t);
    end
    send_cmd(make_cmd(CMD_RUN, 4'd1));
    send_cmd(make_cmd(CMD_RUN, 4'd2));
    send_cmd(make_cmd(CMD_SWITCH, 4'd0));
    t = make_cmd(CMD_SLEEP, 4'd2); t.sleep_ticks = 24'hFFFFFF; t.current_time = '1;
    send_cmd(t);
    send_cmd(make_cmd(CMD_STOP, 4'd0));
    send_cmd(make_cmd(CMD_STOP, 4'd1));
    send_cmd(make_cmd(CMD_SWITCH, 4'd0));
    send_cmd(make_cmd(CMD_SWITCH, 4'd0));
    send_cmd(make_cmd(CMD_FREE, 4'd1));
    send_cmd(make_cmd(CMD_FREE, 4'd15));
    send_cmd(make_cmd(CMD_UNUSED, 4'd15));
    send_cmd(make_cmd(CMD_STOP_FREE, 4'd2));
    send_cmd(make_cmd(CMD_RUN, 4'd0));
    t = '1; t.cmd = CMD_RUN; send_cmd(t);
    t = '0; t.cmd = CMD_ALLOC; send_cmd(t);
    for (int i = 0; i < 17; i++) send_cmd(make_cmd(CMD_ALLOC, 4'd0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 16 : (ph == 1) ? 83 : 0;
      recv_idle = (ph == 0) ? 83 : (ph == 1) ? 16 : 0;
      for (int i = 0; i < 330; i++) begin
        send_cmd(rand_cmd());
        if (i == 100) drain();
      end
    end
    drain();

    $display("Summary: %0d commands sent, %0d results checked across three stall mixes",
             n_cmds, results);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/scr_pkg.sv
sv/scr_cell.sv
sv/scr_list.sv
sv/priority_round_robin_task_scheduler.sv
sv/scr_checker.sv
tb/scr_checker.sv
tb/tb_priority_round_robin_task_scheduler.sv
